// ===== hw/rtl/tlpw_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpw_pkg: shared types and constants for the two-level page walk TLB
// Result kinds, input modes, walk phases, TLB way layout and fault check.
// ----------------------------------------------------------------------------
package tlpw_pkg;

	localparam int SET_BITS_DEF = 4;
	localparam int WAYS_DEF     = 4;

	// page table entry bit positions
	localparam int B_PRESENT = 0;
	localparam int B_RW      = 1;
	localparam int B_US      = 2;
	localparam int B_ACC     = 5;
	localparam int B_DIRTY   = 6;

	typedef enum logic [2:0] {
		KIND_DONE   = 3'd0,
		KIND_FAULT  = 3'd1,
		KIND_READ   = 3'd2,
		KIND_WRITE  = 3'd3,
		KIND_REJECT = 3'd4,
		KIND_FLUSH  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		MODE_XLATE = 2'd0,
		MODE_DATA  = 2'd1,
		MODE_FLUSH = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PDE  = 2'd1,
		PH_PTE  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [19:0] tag;
		logic [31:0] word;
	} way_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] address;
		logic [7:0]  write_byte;
		logic [2:0]  fault_code;
		logic        last;
	} res_t;

	// returns {fault, code}: code bit2 user, bit1 write, bit0 present
	function automatic logic [3:0] fault_check(input logic [31:0] e, input logic wr,
			input logic usr);
		logic [2:0] base;
		base = {usr, wr, 1'b0};
		if (!e[B_PRESENT])
			return {1'b1, base};
		else if (!e[B_US] && usr)
			return {1'b1, base | 3'b001};
		else if (!e[B_RW] && wr && usr)
			return {1'b1, base | 3'b001};
		else
			return 4'b0000;
	endfunction

endpackage

// ===== hw/rtl/two_level_page_walk_tlb_core.sv =====
// ----------------------------------------------------------------------------
// two_level_page_walk_tlb_core: TLB lookup and two-level page table walker
// Translates linear addresses via a set-associative TLB; on a miss emits
// directory and table read requests, accessed/dirty byte writes and faults.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake              | Payload
// s_*      | in  | s_tvalid / s_tready    | s_tuser mode, s_tdata address+flags+data
// m_*      | out | m_tvalid / m_tready    | m_tuser kind, m_tdata result, m_tlast
// APB      | in  | psel & penable, pready | paging_enable (0x0), page_dir_base (0x4)
//
// One item per cycle while s_tready holds; results pass the input stage, then the output buffer.
// The TLB row is read from a set-indexed memory at accept and registered
// with the item; a refill written back in the same cycle is forwarded.
// An item producing two results needs two free slots in the 2-entry output
// buffer, so s_tready drops while that buffer lacks room.
// Reset clears the TLB valid bits per set, the walk state and the buffer.
// ----------------------------------------------------------------------------
module two_level_page_walk_tlb_core
	import tlpw_pkg::*;
#(
	parameter int SET_BITS = SET_BITS_DEF,
	parameter int WAYS     = WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // linear_addr[31:0], is_write[32], user_level[33], read_data[65:34]
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // address[31:0], write_byte[39:32], fault_code[42:40]
	output logic [2:0]  m_tuser,  // kind[2:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NSETS = 1 << SET_BITS;
	localparam logic REG_PAGING = 1'b0;
	localparam logic REG_PDBASE = 1'b1;

	typedef way_t [WAYS-1:0] row_t;

	// configuration
	logic        paging_en_q;
	logic [19:0] pd_base_q;

	// walk state
	phase_t      phase_q, phase_d;
	logic [31:0] pend_lin_q, pend_lin_d;
	logic        pend_wr_q, pend_wr_d;
	logic        pend_usr_q, pend_usr_d;
	logic [31:0] saved_pde_q, saved_pde_d;

	// TLB storage
	row_t               tlb_mem [NSETS];
	logic [NSETS-1:0]   set_valid_q;

	// input stage
	logic                s1_v_q;
	mode_t               mode_s1;
	logic [31:0]         lin_s1;
	logic                wr_s1;
	logic                usr_s1;
	logic [31:0]         data_s1;
	row_t                row_s1;
	logic [SET_BITS-1:0] set_s1;

	// output buffer
	res_t       obuf_q [2];
	logic [1:0] ocnt_q;

	logic                accept, fire, pop;
	logic [SET_BITS-1:0] rd_set;
	logic [31:0]         in_lin;
	logic                tlb_we, flush_now, fwd;
	row_t                eff_row, new_row;
	logic                hit, placed;
	logic [31:0]         hit_word;
	logic [3:0]          chk;
	logic [31:0]         npte, ent;
	logic [31:0]         dir_addr, pte_addr;
	res_t                res0, res1;
	logic [1:0]          nres;
	logic [1:0]          cnt_ap, ocnt_d;
	res_t                ap0, ap1;
	logic                cfg_we;

	// ---------------- configuration port
	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_PDBASE) ? {12'd0, pd_base_q} : {31'd0, paging_en_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_en_q <= 1'b0;
			pd_base_q   <= '0;
		end else if (cfg_we) begin
			if (paddr[2] == REG_PAGING)
				paging_en_q <= pwdata[0];
			else
				pd_base_q <= pwdata[19:0];
		end
	end

	// ---------------- input stage and TLB row read
	assign accept   = s_tvalid & s_tready;
	assign s_tready = !s1_v_q || fire;
	assign in_lin   = s_tdata[31:0];
	// translate reads its own set; walk data reads the set of the pending walk
	assign rd_set   = (mode_t'(s_tuser) == MODE_XLATE) ? in_lin[31 -: SET_BITS]
		: pend_lin_d[31 -: SET_BITS];
	assign fwd      = tlb_we && (rd_set == set_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v_q <= 1'b0;
		else if (s_tready)
			s1_v_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode_t'(s_tuser);
			lin_s1  <= in_lin;
			wr_s1   <= s_tdata[32];
			usr_s1  <= s_tdata[33];
			data_s1 <= s_tdata[65:34];
			set_s1  <= rd_set;
			row_s1  <= fwd ? new_row : tlb_mem[rd_set];
		end
		if (tlb_we)
			tlb_mem[set_s1] <= new_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			set_valid_q <= '0;
		else if (flush_now)
			set_valid_q <= '0;
		else if (tlb_we)
			set_valid_q[set_s1] <= 1'b1;
	end

	// ---------------- item processing
	assign eff_row  = set_valid_q[set_s1] ? row_s1 : '0;
	assign dir_addr = {pd_base_q, pend_lin_q[31:22], 2'b00};
	assign pte_addr = {saved_pde_q[31:12], pend_lin_q[21:12], 2'b00};

	always_comb begin
		hit      = 1'b0;
		hit_word = '0;
		for (int i = 0; i < WAYS; i++) begin
			if (!hit && eff_row[i].word != '0 && eff_row[i].tag == lin_s1[31:12]
					&& (!wr_s1 || eff_row[i].word[B_DIRTY])) begin
				hit      = 1'b1;
				hit_word = eff_row[i].word;
			end
		end
	end

	// PTE with accessed set and dirty set on a write, then PDE permissions folded in
	always_comb begin
		npte = data_s1 | (32'd1 << B_ACC) | ({31'd0, pend_wr_q} << B_DIRTY);
		ent  = npte;
		if (!saved_pde_q[B_RW])
			ent[B_RW] = 1'b0;
		if (!saved_pde_q[B_US])
			ent[B_US] = 1'b0;
	end

	// refill: first way holding the same tag or empty, else shift in at way 0
	always_comb begin
		new_row = eff_row;
		placed  = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if (!placed) begin
				if (eff_row[i].word != '0 && eff_row[i].tag == pend_lin_q[31:12]) begin
					new_row[i].word = ent;
					placed = 1'b1;
				end else if (eff_row[i].word == '0) begin
					new_row[i].tag  = pend_lin_q[31:12];
					new_row[i].word = ent;
					placed = 1'b1;
				end
			end
		end
		if (!placed) begin
			for (int i = WAYS - 1; i > 0; i--)
				new_row[i] = eff_row[i-1];
			new_row[0].tag  = pend_lin_q[31:12];
			new_row[0].word = ent;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		pend_lin_d  = pend_lin_q;
		pend_wr_d   = pend_wr_q;
		pend_usr_d  = pend_usr_q;
		saved_pde_d = saved_pde_q;
		res0        = '{kind: KIND_REJECT, address: '0, write_byte: '0, fault_code: '0,
			last: 1'b1};
		res1        = res0;
		nres        = 2'd1;
		tlb_we      = 1'b0;
		flush_now   = 1'b0;
		chk         = '0;
		case (mode_s1)
			MODE_FLUSH: begin
				flush_now = s1_v_q;
				res0.kind = KIND_FLUSH;
			end
			MODE_XLATE: begin
				if (phase_q != PH_IDLE) begin
					res0.kind = KIND_REJECT;
				end else if (!paging_en_q) begin
					res0.kind    = KIND_DONE;
					res0.address = lin_s1;
				end else if (hit) begin
					chk = fault_check(hit_word, wr_s1, usr_s1);
					if (chk[3]) begin
						res0.kind       = KIND_FAULT;
						res0.address    = lin_s1;
						res0.fault_code = chk[2:0];
					end else begin
						res0.kind    = KIND_DONE;
						res0.address = {hit_word[31:12], lin_s1[11:0]};
					end
				end else begin
					pend_lin_d   = lin_s1;
					pend_wr_d    = wr_s1;
					pend_usr_d   = usr_s1;
					phase_d      = PH_PDE;
					res0.kind    = KIND_READ;
					res0.address = {pd_base_q, lin_s1[31:22], 2'b00};
				end
			end
			MODE_DATA: begin
				if (phase_q == PH_PDE) begin
					if (!data_s1[B_PRESENT]) begin
						phase_d         = PH_IDLE;
						res0.kind       = KIND_FAULT;
						res0.address    = pend_lin_q;
						res0.fault_code = {pend_usr_q, pend_wr_q, 1'b0};
					end else begin
						saved_pde_d  = data_s1;
						phase_d      = PH_PTE;
						res1.kind    = KIND_READ;
						res1.address = {data_s1[31:12], pend_lin_q[21:12], 2'b00};
						if (!data_s1[B_ACC]) begin
							res0.kind       = KIND_WRITE;
							res0.address    = dir_addr;
							res0.write_byte = data_s1[7:0] | (8'd1 << B_ACC)
								| ({7'd0, pend_wr_q} << B_DIRTY);
							res0.last       = 1'b0;
							nres            = 2'd2;
						end else begin
							res0 = res1;
						end
					end
				end else if (phase_q == PH_PTE) begin
					phase_d = PH_IDLE;
					chk     = fault_check(ent, pend_wr_q, pend_usr_q);
					res1.kind    = KIND_DONE;
					res1.address = {ent[31:12], pend_lin_q[11:0]};
					if (chk[3]) begin
						res0.kind       = KIND_FAULT;
						res0.address    = pend_lin_q;
						res0.fault_code = chk[2:0];
					end else begin
						tlb_we = s1_v_q;
						if (npte != data_s1) begin
							res0.kind       = KIND_WRITE;
							res0.address    = pte_addr;
							res0.write_byte = npte[7:0];
							res0.last       = 1'b0;
							nres            = 2'd2;
						end else begin
							res0 = res1;
						end
					end
				end
			end
			default: begin
				res0.kind = KIND_REJECT;
			end
		endcase
		// only commit when the item actually leaves the input stage
		if (!fire) begin
			phase_d     = phase_q;
			pend_lin_d  = pend_lin_q;
			pend_wr_d   = pend_wr_q;
			pend_usr_d  = pend_usr_q;
			saved_pde_d = saved_pde_q;
			tlb_we      = 1'b0;
			flush_now   = 1'b0;
		end
	end

	// nres depends only on s1 registers and walk state, not on m_tready
	assign fire = s1_v_q && ({1'b0, ocnt_q} + {1'b0, nres} <= 3'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pend_lin_q  <= '0;
			pend_wr_q   <= 1'b0;
			pend_usr_q  <= 1'b0;
			saved_pde_q <= '0;
		end else begin
			phase_q     <= phase_d;
			pend_lin_q  <= pend_lin_d;
			pend_wr_q   <= pend_wr_d;
			pend_usr_q  <= pend_usr_d;
			saved_pde_q <= saved_pde_d;
		end
	end

	// ---------------- output buffer, two entries
	assign m_tvalid = (ocnt_q != 2'd0);
	assign pop      = m_tvalid & m_tready;
	assign m_tuser  = obuf_q[0].kind;
	assign m_tdata  = {5'd0, obuf_q[0].fault_code, obuf_q[0].write_byte, obuf_q[0].address};
	assign m_tlast  = obuf_q[0].last;

	assign cnt_ap = ocnt_q - {1'b0, pop};
	assign ap0    = pop ? obuf_q[1] : obuf_q[0];
	assign ap1    = obuf_q[1];
	assign ocnt_d = cnt_ap + (fire ? nres : 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ocnt_q <= '0;
		else
			ocnt_q <= ocnt_d;
	end

	always_ff @(posedge clk) begin
		obuf_q[0] <= (cnt_ap == 2'd0 && fire) ? res0 : ap0;
		if (cnt_ap == 2'd0)
			obuf_q[1] <= res1;
		else if (cnt_ap == 2'd1 && fire)
			obuf_q[1] <= res0;
		else
			obuf_q[1] <= ap1;
	end

endmodule

// ===== hw/rtl/tlpw_checker.sv =====
// ----------------------------------------------------------------------------
// tlpw_checker: port-level checks for the page walk TLB core
// Watches the result channel for stall stability and per-kind field rules.
// ----------------------------------------------------------------------------
module tlpw_checker
	import tlpw_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// a byte write always precedes a read request or a translation
	a_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_WRITE |-> !m_tlast)
		else $error("write request marked last");

	a_only_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_WRITE |-> m_tlast)
		else $error("non-write result not marked last");

	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_REJECT || m_tuser == KIND_FLUSH) |-> m_tdata == '0)
		else $error("reject or flush carries payload");

	a_code_only_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != KIND_FAULT |-> m_tdata[42:40] == 3'd0)
		else $error("fault code on non-fault result");

endmodule

bind two_level_page_walk_tlb_core tlpw_checker u_tlpw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
